>>> hw/rtl/assert_macros.svh
// Concurrent assertion helpers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising edge of a given clock, off while reset is low.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check a property on the default clock and reset of the module.
`define ASSERT_DEF(lbl, prop, msg) `ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> hw/rtl/imm_pkg.sv
package imm_pkg;

  localparam int unsigned MAX_DIM_DEF   = 8;
  localparam int unsigned ELEM_BITS_DEF = 16;

  localparam int unsigned ELEM_W    = 16;
  localparam int unsigned PROD_W    = 35;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned CFG_W     = 4;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B = 2'd3;

  localparam logic OP_LOAD_A = 1'b0;
  localparam logic OP_LOAD_B = 1'b1;

  typedef struct packed {
    logic                     opcode;
    logic signed [ELEM_W-1:0] element;
  } in_word_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] product;
    logic [IDX_W-1:0]         out_row;
    logic [IDX_W-1:0]         out_col;
    logic                     size_error;
    logic                     last;
  } out_word_t;

endpackage

>>> hw/rtl/imm_ram.sv
module imm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/integer_matrix_multiply_top.sv
// Loading: one word per cycle while idle; results of a run start after the
// last B word. Pass: each multiply-accumulate term goes through the RAM read,
// multiply and add states, and each result through the emit state. Input
// stalls during the pass. Reset clears the load counters and control, sets
// the size registers to 1; the element RAMs hold no reset value, and the user
// must write elements before a pass reads them; the block doesn't enforce it.
`include "assert_macros.svh"

module integer_matrix_multiply_top #(
  parameter int unsigned MAX_DIM   = imm_pkg::MAX_DIM_DEF,
  parameter int unsigned ELEM_BITS = imm_pkg::ELEM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  imm_pkg::in_word_t              in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output imm_pkg::out_word_t             out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [imm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [imm_pkg::CFG_W-1:0]      cfg_data_i
);

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = $clog2(MAX_DIM + 1);
  localparam int unsigned EB    = ELEM_BITS;
  localparam int unsigned PW    = imm_pkg::PROD_W;
  localparam int unsigned IW    = imm_pkg::IDX_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_MUL  = 5'b00100,
    S_ACC  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  function automatic logic [DW-1:0] clamp_dim(input logic [imm_pkg::CFG_W-1:0] d);
    if (d == '0) begin
      return DW'(1);
    end else if ({1'b0, d} > 5'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end else begin
      return DW'(d);
    end
  endfunction

  state_e                   state_q, state_d;
  logic [imm_pkg::CFG_W-1:0] rows_a_q, cols_a_q, rows_b_q, cols_b_q;
  logic [CW-1:0]            count_a_q, count_a_d, count_b_q, count_b_d, count_b_nx;
  logic [DW-1:0]            r_q, r_d, c_q, c_d, j_q, j_d;
  logic [AW-1:0]            a_row_q, a_row_d, b_addr_q, b_addr_d;
  logic signed [2*EB-1:0]   prod_q;
  logic signed [PW-1:0]     acc_q, acc_d;
  logic                     err_q, err_d;
  logic                     out_valid_q, out_valid_d;
  imm_pkg::out_word_t       out_q;

  logic [DW-1:0]            dim_ra, dim_ca, dim_rb, dim_cb;
  logic [CW-1:0]            num_a, num_b;
  logic [EB-1:0]            elem_st;
  logic                     in_acc, we_a, we_b, start_w, emit_fire, last_w, rd_en;
  logic [AW-1:0]            raddr_a;
  logic [EB-1:0]            rd_a, rd_b;

  assign dim_ra = clamp_dim(rows_a_q);
  assign dim_ca = clamp_dim(cols_a_q);
  assign dim_rb = clamp_dim(rows_b_q);
  assign dim_cb = clamp_dim(cols_b_q);
  assign num_a  = CW'(dim_ra) * CW'(dim_ca);
  assign num_b  = CW'(dim_rb) * CW'(dim_cb);

  assign elem_st    = EB'($unsigned(in_data_i.element));
  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  assign we_a = in_acc && (in_data_i.opcode == imm_pkg::OP_LOAD_A) && (count_a_q < num_a);
  assign we_b = in_acc && (in_data_i.opcode == imm_pkg::OP_LOAD_B) && (count_b_q < num_b);
  assign count_b_nx = we_b ? CW'(count_b_q + 1'b1) : count_b_q;
  assign start_w = in_acc && (in_data_i.opcode == imm_pkg::OP_LOAD_B) && (count_b_nx >= num_b);

  assign rd_en     = (state_q == S_READ);
  assign raddr_a   = a_row_q + AW'(j_q);
  assign emit_fire = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign last_w    = err_q || ((DW'(r_q + 1'b1) == dim_ra) && (DW'(c_q + 1'b1) == dim_cb));

  imm_ram #(.WIDTH(EB), .DEPTH(DEPTH)) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (AW'(count_a_q)),
    .wdata_i (elem_st),
    .re_i    (rd_en),
    .raddr_i (raddr_a),
    .rdata_o (rd_a)
  );

  imm_ram #(.WIDTH(EB), .DEPTH(DEPTH)) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (AW'(count_b_q)),
    .wdata_i (elem_st),
    .re_i    (rd_en),
    .raddr_i (b_addr_q),
    .rdata_o (rd_b)
  );

  always_comb begin
    state_d   = state_q;
    count_a_d = count_a_q;
    count_b_d = count_b_q;
    r_d       = r_q;
    c_d       = c_q;
    j_d       = j_q;
    a_row_d   = a_row_q;
    b_addr_d  = b_addr_q;
    acc_d     = acc_q;
    err_d     = err_q;
    case (state_q)
      S_IDLE: begin
        if (we_a) begin
          count_a_d = CW'(count_a_q + 1'b1);
        end
        if (in_acc && (in_data_i.opcode == imm_pkg::OP_LOAD_B)) begin
          count_b_d = count_b_nx;
        end
        if (start_w) begin
          count_a_d = '0;
          count_b_d = '0;
          r_d       = '0;
          c_d       = '0;
          j_d       = '0;
          a_row_d   = '0;
          b_addr_d  = '0;
          acc_d     = '0;
          err_d     = (dim_ca != dim_rb);
          state_d   = (dim_ca != dim_rb) ? S_EMIT : S_READ;
        end
      end
      S_READ: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        acc_d = acc_q + PW'(prod_q);
        if (DW'(j_q + 1'b1) == dim_ca) begin
          state_d = S_EMIT;
        end else begin
          j_d      = DW'(j_q + 1'b1);
          b_addr_d = b_addr_q + AW'(dim_cb);
          state_d  = S_READ;
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          if (last_w) begin
            state_d = S_IDLE;
          end else begin
            if (DW'(c_q + 1'b1) == dim_cb) begin
              c_d      = '0;
              r_d      = DW'(r_q + 1'b1);
              a_row_d  = a_row_q + AW'(dim_ca);
              b_addr_d = '0;
            end else begin
              c_d      = DW'(c_q + 1'b1);
              b_addr_d = AW'(DW'(c_q + 1'b1));
            end
            j_d     = '0;
            acc_d   = '0;
            state_d = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rows_a_q    <= imm_pkg::CFG_W'(1);
      cols_a_q    <= imm_pkg::CFG_W'(1);
      rows_b_q    <= imm_pkg::CFG_W'(1);
      cols_b_q    <= imm_pkg::CFG_W'(1);
      count_a_q   <= '0;
      count_b_q   <= '0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_a_q   <= count_a_d;
      count_b_q   <= count_b_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          imm_pkg::REG_ROWS_A: rows_a_q <= cfg_data_i;
          imm_pkg::REG_COLS_A: cols_a_q <= cfg_data_i;
          imm_pkg::REG_ROWS_B: rows_b_q <= cfg_data_i;
          imm_pkg::REG_COLS_B: cols_b_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r_q      <= r_d;
    c_q      <= c_d;
    j_q      <= j_d;
    a_row_q  <= a_row_d;
    b_addr_q <= b_addr_d;
    acc_q    <= acc_d;
    if (state_q == S_MUL) begin
      prod_q <= $signed(rd_a) * $signed(rd_b);
    end
    if (emit_fire) begin
      out_q.product    <= err_q ? '0 : acc_q;
      out_q.out_row    <= err_q ? '0 : IW'(r_q);
      out_q.out_col    <= err_q ? '0 : IW'(c_q);
      out_q.size_error <= err_q;
      out_q.last       <= last_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_DEF(a_start_stalls_input, start_w |=> !in_ready_o, "input not stalled after run start")
  `ASSERT_DEF(a_last_frees_input, (emit_fire && last_w) |=> in_ready_o, "input not freed after last word")
  `ASSERT_DEF(a_error_word_shape, (out_valid_o && out_data_o.size_error) |-> (out_data_o.last && (out_data_o.product == '0)), "error word malformed")

endmodule
